FILE: rtl/lfd_pkg.sv
// shared types and constants for the length-framed deframer
// no dependencies
`default_nettype none

package lfd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'd153;
	localparam logic [BYTE_W-1:0] MIN_FRAME_BYTES = 8'd4;
	localparam logic [BYTE_W-1:0] MAX_FRAME_BYTES = 8'd128;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_CKSUM  = 2'd1,
		ST_BADLEN = 2'd2,
		ST_TRUNC  = 2'd3
	} status_t;

	// classified input byte, front to back
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              dg_start;
		logic              marker_hit;
		logic              len_bad;
		logic              len_min;
	} cmd_t;

	// one result, back to output queue
	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] payload;
		logic              ok;
		status_t           status;
	} res_t;

endpackage

`default_nettype wire

FILE: rtl/lfd_queue.sv
// small first-word-fall-through queue
// no package dependencies
`default_nettype none

module lfd_queue #(
	parameter int unsigned W  = 8,
	parameter int unsigned AW = 1
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         wr_en,
	input  wire logic [W-1:0] wr_data,
	output logic              full,
	input  wire logic         rd_en,
	output logic [W-1:0]      rd_data,
	output logic              empty
);

	localparam int unsigned DEPTH = 1 << AW;
	localparam logic [AW:0] DEPTH_CNT = (AW+1)'(DEPTH);

	logic [W-1:0]  entries_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;
	logic          do_wr;
	logic          do_rd;

	assign full    = (count_q == DEPTH_CNT);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entries_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/lfd_front.sv
// front end: start marker register and byte classification
// depends on lfd_pkg
`default_nettype none

module lfd_front (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_valid,
	input  wire logic [lfd_pkg::BYTE_W-1:0] cfg_data,
	input  wire logic [lfd_pkg::BYTE_W-1:0] data_byte,
	input  wire logic                      datagram_start,
	output lfd_pkg::cmd_t                  cmd
);

	logic [lfd_pkg::BYTE_W-1:0] start_marker_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= lfd_pkg::START_MARKER_RST;
		end else if (cfg_valid) begin
			start_marker_q <= cfg_data;
		end
	end

	// length checks only matter when the back end expects a length byte
	always_comb begin
		cmd.data       = data_byte;
		cmd.dg_start   = datagram_start;
		cmd.marker_hit = (data_byte == start_marker_q);
		cmd.len_bad    = (data_byte < lfd_pkg::MIN_FRAME_BYTES) ||
		                 (data_byte > lfd_pkg::MAX_FRAME_BYTES);
		cmd.len_min    = (data_byte == lfd_pkg::MIN_FRAME_BYTES);
	end

endmodule

`default_nettype wire

FILE: rtl/lfd_back.sv
// back end: frame parse state machine and running checksums
// depends on lfd_pkg
`default_nettype none

module lfd_back (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   cmd_valid,
	input  wire lfd_pkg::cmd_t cmd,
	output logic        cmd_take,
	input  wire logic   res_full,
	output logic        res_push,
	output lfd_pkg::res_t res
);

	typedef enum logic [4:0] {
		PH_IDLE = 5'b00001,
		PH_LEN  = 5'b00010,
		PH_PAY  = 5'b00100,
		PH_CKA  = 5'b01000,
		PH_CKB  = 5'b10000
	} phase_t;

	phase_t                     phase_q, phase_d;
	logic [lfd_pkg::BYTE_W-1:0] remain_q, remain_d;
	logic [lfd_pkg::BYTE_W-1:0] sum_a_q, sum_a_d;
	logic [lfd_pkg::BYTE_W-1:0] sum_b_q, sum_b_d;
	logic                       cka_match_q, cka_match_d;
	logic                       has_res;

	// one request per cycle while the output queue has room
	assign cmd_take = cmd_valid && !res_full;
	assign res_push = cmd_take && has_res;

	always_comb begin
		phase_d     = phase_q;
		remain_d    = remain_q;
		sum_a_d     = sum_a_q;
		sum_b_d     = sum_b_q;
		cka_match_d = cka_match_q;
		has_res     = 1'b0;
		res.kind    = 1'b1;
		res.payload = '0;
		res.ok      = 1'b0;
		res.status  = lfd_pkg::ST_OK;

		if (cmd.dg_start) begin
			// a new datagram cuts off an open frame
			if (phase_q != PH_IDLE) begin
				has_res    = 1'b1;
				res.status = lfd_pkg::ST_TRUNC;
			end
			phase_d = cmd.marker_hit ? PH_LEN : PH_IDLE;
		end else begin
			case (phase_q)
				PH_LEN: begin
					if (cmd.len_bad) begin
						phase_d    = PH_IDLE;
						has_res    = 1'b1;
						res.status = lfd_pkg::ST_BADLEN;
					end else begin
						remain_d    = cmd.data - lfd_pkg::MIN_FRAME_BYTES;
						sum_a_d     = cmd.data;
						sum_b_d     = cmd.data;
						cka_match_d = 1'b0;
						phase_d     = cmd.len_min ? PH_CKA : PH_PAY;
					end
				end
				PH_PAY: begin
					sum_a_d     = sum_a_q + cmd.data;
					sum_b_d     = sum_b_q + sum_a_d;
					remain_d    = remain_q - 1'b1;
					if (remain_d == '0) begin
						phase_d = PH_CKA;
					end
					has_res     = 1'b1;
					res.kind    = 1'b0;
					res.payload = cmd.data;
				end
				PH_CKA: begin
					cka_match_d = (cmd.data == sum_a_q);
					phase_d     = PH_CKB;
				end
				PH_CKB: begin
					phase_d = PH_IDLE;
					has_res = 1'b1;
					if (cka_match_q && (cmd.data == sum_b_q)) begin
						res.ok     = 1'b1;
						res.status = lfd_pkg::ST_OK;
					end else begin
						res.status = lfd_pkg::ST_CKSUM;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else if (cmd_take) begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			remain_q    <= remain_d;
			sum_a_q     <= sum_a_d;
			sum_b_q     <= sum_b_d;
			cka_match_q <= cka_match_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/stx_length_frame_deframer.sv
// top level of the length-framed deframer with two running checksums
// depends on lfd_pkg, lfd_front, lfd_queue, lfd_back
`default_nettype none

// channel   direction  handshake              payload
// input     in         push / full            data_byte, datagram_start
// result    out        empty / pop            result_kind, payload_byte,
//                                             frame_ok, frame_status
// config    in         cfg_valid / cfg_ready  cfg_data (start marker)
//
// one byte per cycle sustained while full is low; the result a byte causes
// goes through the request queue and the parser into the output queue and
// from there onto the result ports
// reset empties both queues, sets the parser idle and the marker to 153
// full rises only when the request queue is full, which happens only while
// the consumer stops popping and the output queue has filled

module stx_length_frame_deframer #(
	parameter int unsigned CMD_AW = 1,
	parameter int unsigned RES_AW = 1
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// input channel
	input  wire logic                       push,
	output logic                            full,
	input  wire logic [lfd_pkg::BYTE_W-1:0] data_byte,
	input  wire logic                       datagram_start,
	// result channel
	input  wire logic                       pop,
	output logic                            empty,
	output logic                            result_kind,
	output logic [lfd_pkg::BYTE_W-1:0]      payload_byte,
	output logic                            frame_ok,
	output logic [1:0]                      frame_status,
	// configuration channel
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [lfd_pkg::BYTE_W-1:0] cfg_data
);

	lfd_pkg::cmd_t cmd_in;
	lfd_pkg::cmd_t cmd_out;
	lfd_pkg::res_t res_in;
	lfd_pkg::res_t res_out;
	logic          cmd_empty;
	logic          cmd_take;
	logic          res_full;
	logic          res_push;

	// the marker register takes any write at once
	assign cfg_ready = 1'b1;

	// classify each byte and latch the start marker
	lfd_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_data       (cfg_data),
		.data_byte      (data_byte),
		.datagram_start (datagram_start),
		.cmd            (cmd_in)
	);

	// request queue between front and back
	lfd_queue #(
		.W  ($bits(lfd_pkg::cmd_t)),
		.AW (CMD_AW)
	) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (cmd_in),
		.full    (full),
		.rd_en   (cmd_take),
		.rd_data (cmd_out),
		.empty   (cmd_empty)
	);

	// parser: stalls only when the output queue is full
	lfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!cmd_empty),
		.cmd       (cmd_out),
		.cmd_take  (cmd_take),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	// output queue, the oldest result sits on the ports
	lfd_queue #(
		.W  ($bits(lfd_pkg::res_t)),
		.AW (RES_AW)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_out),
		.empty   (empty)
	);

	assign result_kind  = res_out.kind;
	assign payload_byte = res_out.payload;
	assign frame_ok     = res_out.ok;
	assign frame_status = res_out.status;

	// the parser never writes a result into a full output queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into full output queue");

	// the parser only takes requests that are there
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> !cmd_empty)
		else $error("request taken from empty queue");

	// payload results carry no status
	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result_kind) |-> (!frame_ok && frame_status == lfd_pkg::ST_OK))
		else $error("payload result with status bits");

	// frame_ok agrees with the status code
	a_ok_status: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result_kind) |-> (frame_ok == (frame_status == lfd_pkg::ST_OK)))
		else $error("frame_ok disagrees with frame_status");

endmodule

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 100ps
// testbench for stx_length_frame_deframer: a directed table, then random frames
// checks every result against its typed table row or an in-bench predictor; needs lfd_pkg and the rtl top

module testbench;

	localparam int WATCHDOG_LIMIT = 2000;   // cycles with no accepted request
	localparam int DRAIN_CYCLES = 16;       // pipeline settle after the last result
	localparam int ITEMS_PER_PHASE = 375;
	localparam int MAX_SHOWN = 10;
	localparam int NUM_DIR_ROWS = 25;

	// parser phases of the predictor
	typedef enum logic [2:0] {P_IDLE, P_LEN, P_PAY, P_CKA, P_CKB} parse_phase_t;

	// one directed row; res is used only when typed is set
	typedef struct packed {
		logic [7:0]    data;
		logic          dg_start;
		logic          typed;
		logic          has_res;
		lfd_pkg::res_t res;
	} dir_row_t;

	localparam lfd_pkg::res_t R_NONE   =
		'{kind: 1'b0, payload: 8'h00, ok: 1'b0, status: lfd_pkg::ST_OK};
	localparam lfd_pkg::res_t R_OK     =
		'{kind: 1'b1, payload: 8'h00, ok: 1'b1, status: lfd_pkg::ST_OK};
	localparam lfd_pkg::res_t R_CKSUM  =
		'{kind: 1'b1, payload: 8'h00, ok: 1'b0, status: lfd_pkg::ST_CKSUM};
	localparam lfd_pkg::res_t R_BADLEN =
		'{kind: 1'b1, payload: 8'h00, ok: 1'b0, status: lfd_pkg::ST_BADLEN};
	localparam lfd_pkg::res_t R_TRUNC  =
		'{kind: 1'b1, payload: 8'h00, ok: 1'b0, status: lfd_pkg::ST_TRUNC};
	localparam lfd_pkg::res_t R_PAY_FF =
		'{kind: 1'b0, payload: 8'hFF, ok: 1'b0, status: lfd_pkg::ST_OK};
	localparam lfd_pkg::res_t R_PAY_00 =
		'{kind: 1'b0, payload: 8'h00, ok: 1'b0, status: lfd_pkg::ST_OK};
	localparam lfd_pkg::res_t R_PAY_12 =
		'{kind: 1'b0, payload: 8'h12, ok: 1'b0, status: lfd_pkg::ST_OK};

	// directed part, run with the reset marker 0x99
	localparam dir_row_t DIR_ROWS [NUM_DIR_ROWS] = '{
		'{8'h99, 1'b1, 1'b1, 1'b0, R_NONE},   // reset marker opens a frame
		'{8'h03, 1'b0, 1'b1, 1'b1, R_BADLEN}, // length just below the minimum
		'{8'h99, 1'b1, 1'b1, 1'b0, R_NONE},
		'{8'h04, 1'b0, 1'b1, 1'b0, R_NONE},   // empty payload, straight to checksum a
		'{8'h04, 1'b0, 1'b0, 1'b0, R_NONE},
		'{8'h04, 1'b0, 1'b1, 1'b1, R_OK},     // both sums equal the length byte
		'{8'h00, 1'b0, 1'b1, 1'b0, R_NONE},   // byte after a closed frame
		'{8'h98, 1'b1, 1'b1, 1'b0, R_NONE},   // datagram start that is not the marker
		'{8'hFF, 1'b0, 1'b1, 1'b0, R_NONE},
		'{8'h99, 1'b1, 1'b1, 1'b0, R_NONE},
		'{8'h81, 1'b0, 1'b1, 1'b1, R_BADLEN}, // one above the buffer size
		'{8'h06, 1'b0, 1'b1, 1'b0, R_NONE},   // rest of that datagram is dropped
		'{8'h99, 1'b1, 1'b1, 1'b0, R_NONE},
		'{8'h06, 1'b0, 1'b1, 1'b0, R_NONE},   // two payload bytes
		'{8'hFF, 1'b0, 1'b1, 1'b1, R_PAY_FF},
		'{8'h00, 1'b0, 1'b1, 1'b1, R_PAY_00},
		'{8'h05, 1'b0, 1'b0, 1'b0, R_NONE},   // correct checksum a
		'{8'h00, 1'b0, 1'b1, 1'b1, R_CKSUM},  // wrong checksum b
		'{8'h99, 1'b1, 1'b1, 1'b0, R_NONE},
		'{8'h05, 1'b0, 1'b1, 1'b0, R_NONE},
		'{8'h12, 1'b0, 1'b1, 1'b1, R_PAY_12},
		'{8'h99, 1'b1, 1'b1, 1'b1, R_TRUNC},  // new datagram mid-frame, reopens
		'{8'hFF, 1'b0, 1'b1, 1'b1, R_BADLEN}, // length of all ones
		'{8'h99, 1'b1, 1'b1, 1'b0, R_NONE},
		'{8'h00, 1'b0, 1'b1, 1'b1, R_BADLEN}  // zero length
	};

	// dut ports, all inputs known from time zero
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  data_byte = 8'h00;
	logic        datagram_start = 1'b0;
	logic        pop = 1'b0;
	logic        empty;
	logic        result_kind;
	logic [7:0]  payload_byte;
	logic        frame_ok;
	logic [1:0]  frame_status;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data = 8'h00;

	// typed expectation that travels with the byte on the input side
	logic          row_typed = 1'b0;
	logic          row_has_res = 1'b0;
	lfd_pkg::res_t row_res = R_NONE;

	// predictor state
	logic [7:0]   mdl_marker = lfd_pkg::START_MARKER_RST;
	parse_phase_t mdl_phase = P_IDLE;
	logic [7:0]   mdl_left = 8'h00;
	logic [7:0]   mdl_sum_a = 8'h00;
	logic [7:0]   mdl_sum_b = 8'h00;
	logic         mdl_a_ok = 1'b0;

	lfd_pkg::res_t frame_out_q [$];   // results still owed by the dut
	logic [7:0]   cur_marker = lfd_pkg::START_MARKER_RST;
	bit           gaps_on = 1'b1;
	int           mismatch_cnt = 0;
	int           idle_cycles = 0;
	int           n_bytes = 0;
	int           n_cfg = 0;
	int           n_payload = 0;
	int           n_status [4] = '{0, 0, 0, 0};

	stx_length_frame_deframer dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.data_byte      (data_byte),
		.datagram_start (datagram_start),
		.pop            (pop),
		.empty          (empty),
		.result_kind    (result_kind),
		.payload_byte   (payload_byte),
		.frame_ok       (frame_ok),
		.frame_status   (frame_status),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic lfd_pkg::res_t mk_status(input lfd_pkg::status_t st);
		lfd_pkg::res_t r;
		r = '0;
		r.kind = 1'b1;
		r.ok = (st == lfd_pkg::ST_OK);
		r.status = st;
		return r;
	endfunction

	// advance the predictor by one accepted byte
	task automatic deframe_byte(input logic [7:0] b, input logic s,
			output logic got, output lfd_pkg::res_t r);
		got = 1'b0;
		r = '0;
		if (s) begin
			// a datagram start closes any open frame, then may open a new one
			if (mdl_phase != P_IDLE) begin
				got = 1'b1;
				r = mk_status(lfd_pkg::ST_TRUNC);
			end
			mdl_phase = (b == mdl_marker) ? P_LEN : P_IDLE;
		end else begin
			case (mdl_phase)
				P_LEN: begin
					if (b < lfd_pkg::MIN_FRAME_BYTES || b > lfd_pkg::MAX_FRAME_BYTES) begin
						mdl_phase = P_IDLE;
						got = 1'b1;
						r = mk_status(lfd_pkg::ST_BADLEN);
					end else begin
						mdl_left = b - lfd_pkg::MIN_FRAME_BYTES;
						mdl_sum_a = b;
						mdl_sum_b = b;
						mdl_a_ok = 1'b0;
						mdl_phase = (mdl_left == 8'h00) ? P_CKA : P_PAY;
					end
				end
				P_PAY: begin
					mdl_sum_a = mdl_sum_a + b;
					mdl_sum_b = mdl_sum_b + mdl_sum_a;
					mdl_left = mdl_left - 8'h01;
					if (mdl_left == 8'h00)
						mdl_phase = P_CKA;
					got = 1'b1;
					r.payload = b;
				end
				P_CKA: begin
					mdl_a_ok = (b == mdl_sum_a);
					mdl_phase = P_CKB;
				end
				P_CKB: begin
					mdl_phase = P_IDLE;
					got = 1'b1;
					r = mk_status((mdl_a_ok && b == mdl_sum_b) ?
						lfd_pkg::ST_OK : lfd_pkg::ST_CKSUM);
				end
				default: mdl_phase = P_IDLE;
			endcase
		end
	endtask

	// sample every handshake at the rising edge, before the driven inputs move
	always @(posedge clk) begin : monitor
		logic got;
		lfd_pkg::res_t r;
		lfd_pkg::res_t want;
		if (arst_n) begin
			// result side: compare with the oldest expectation
			if (pop && !empty) begin
				if (frame_out_q.size() == 0) begin
					if (mismatch_cnt < MAX_SHOWN)
						$display("unexpected result: kind %0d byte %h ok %0d status %0d",
							result_kind, payload_byte, frame_ok, frame_status);
					mismatch_cnt++;
				end else begin
					want = frame_out_q.pop_front();
					if (result_kind !== want.kind || payload_byte !== want.payload ||
							frame_ok !== want.ok || frame_status !== want.status) begin
						if (mismatch_cnt < MAX_SHOWN)
							$display("mismatch: want kind %0d byte %h ok %0d status %0d, %s",
								want.kind, want.payload, want.ok, want.status,
								$sformatf("got kind %0d byte %h ok %0d status %0d",
									result_kind, payload_byte, frame_ok, frame_status));
						mismatch_cnt++;
					end
				end
				if (result_kind === 1'b1)
					n_status[frame_status]++;
				else
					n_payload++;
			end
			// marker write request
			if (cfg_valid && cfg_ready) begin
				mdl_marker = cfg_data;
				n_cfg++;
			end
			// input request: predict, or take the typed value of a directed row
			if (push && !full) begin
				deframe_byte(data_byte, datagram_start, got, r);
				if (row_typed) begin
					got = row_has_res;
					r = row_res;
				end
				if (got)
					frame_out_q.push_back(r);
				n_bytes++;
			end
			// watchdog on accepted requests of any channel
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no request accepted for %0d cycles", idle_cycles);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// consumer: pops with random stall bursts while gaps are on
	initial begin
		forever begin
			@(posedge clk);
			if (gaps_on && $urandom_range(0, 4) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			pop <= 1'b1;
		end
	end

	// one input request; returns at the edge where it was accepted
	task automatic send_byte(input logic [7:0] b, input logic s, input logic typed,
			input logic has_res, input lfd_pkg::res_t r);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		push <= 1'b1;
		data_byte <= b;
		datagram_start <= s;
		row_typed <= typed;
		row_has_res <= has_res;
		row_res <= r;
		do @(posedge clk); while (full);
	endtask

	// stop pushing, wait for every owed result, then let the pipe settle
	task automatic drain_results();
		push <= 1'b0;
		@(posedge clk);
		while (frame_out_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_marker(input logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_marker = v;
	endtask

	// one random datagram: mostly well-formed frames, some broken ones, a bit of noise
	task automatic send_random_group(inout int count);
		int pick;
		int len;
		int corrupt;
		int keep;
		logic [7:0] sum_a;
		logic [7:0] sum_b;
		logic [7:0] p;
		logic [7:0] frame [$];
		pick = $urandom_range(0, 99);
		if (pick < 80) begin
			// frame with correct sums unless corrupted; few at the full buffer size
			len = ($urandom_range(0, 39) == 0) ? int'(lfd_pkg::MAX_FRAME_BYTES)
				: $urandom_range(4, 14);
			frame.push_back(cur_marker);
			frame.push_back(8'(len));
			sum_a = 8'(len);
			sum_b = 8'(len);
			for (int i = 4; i < len; i++) begin
				p = 8'($urandom);
				sum_a = sum_a + p;
				sum_b = sum_b + sum_a;
				frame.push_back(p);
			end
			corrupt = $urandom_range(0, 9);
			frame.push_back((corrupt == 1) ? sum_a ^ 8'($urandom_range(1, 255)) : sum_a);
			frame.push_back((corrupt == 2) ? sum_b ^ 8'($urandom_range(1, 255)) : sum_b);
			if (pick >= 70) begin
				// cut short; the next datagram start truncates it
				keep = $urandom_range(1, frame.size() - 1);
				while (frame.size() > keep) void'(frame.pop_back());
			end else if ($urandom_range(0, 5) == 0) begin
				repeat ($urandom_range(1, 2)) frame.push_back(8'($urandom));
			end
		end else if (pick < 88) begin
			// length out of range, then bytes that must be dropped
			frame.push_back(cur_marker);
			frame.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 3))
				: 8'($urandom_range(129, 255)));
			repeat ($urandom_range(0, 2)) frame.push_back(8'($urandom));
		end else if (pick < 94) begin
			// datagram whose first byte is not the marker
			frame.push_back(cur_marker ^ 8'($urandom_range(1, 255)));
			repeat ($urandom_range(0, 3)) frame.push_back(8'($urandom));
		end else begin
			// loose noise, not counted
			repeat ($urandom_range(1, 4))
				send_byte(8'($urandom), $urandom_range(0, 3) == 0, 1'b0, 1'b0, R_NONE);
			return;
		end
		for (int i = 0; i < frame.size(); i++)
			send_byte(frame[i], i == 0, 1'b0, 1'b0, R_NONE);
		count += frame.size();
	endtask

	initial begin : stimulus
		int sent;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at the reset marker
		for (int i = 0; i < NUM_DIR_ROWS; i++)
			send_byte(DIR_ROWS[i].data, DIR_ROWS[i].dg_start, DIR_ROWS[i].typed,
				DIR_ROWS[i].has_res, DIR_ROWS[i].res);

		// random phases: marker at both extremes, a random value, then back to reset
		for (int ph = 0; ph < 4; ph++) begin
			drain_results();
			case (ph)
				0: write_marker(8'h00);
				1: write_marker(8'hFF);
				2: write_marker(8'($urandom));
				default: write_marker(lfd_pkg::START_MARKER_RST);
			endcase
			if (ph == 3)
				gaps_on = 1'b0;   // last stretch runs at full rate
			sent = 0;
			while (sent < ITEMS_PER_PHASE)
				send_random_group(sent);
		end
		drain_results();

		mismatch_cnt += frame_out_q.size();
		$display("covered %0d input bytes under %0d marker settings, %0d payload bytes back",
			n_bytes, n_cfg + 1, n_payload);
		$display("frame ends: %0d ok, %0d checksum, %0d length, %0d truncated; %0d mismatches",
			n_status[0], n_status[1], n_status[2], n_status[3], mismatch_cnt);
		if (mismatch_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
